// ===== hw/rtl/cgft_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgft_pkg
// Shared constants and types for the codon Gray fold triangle block.
// ----------------------------------------------------------------------------
package cgft_pkg;

	// Width of a class fraction and of its bit prefix.
	localparam int FRAC_BITS = 16;
	// Per-class codon count saturates here.
	localparam int CNT_W = 5;
	localparam logic [CNT_W-1:0] CNT_MAX = 5'd31;
	// Configuration values and results are signed Q2.14.
	localparam int VAL_W = 16;
	// Range difference plus one guard bit, times a zero-extended fraction.
	localparam int DIFF_W = VAL_W + 1;
	localparam int PROD_W = DIFF_W + FRAC_BITS + 1;
	// Sum of the low bound and the scaled offset before saturation.
	localparam int SUM_W = VAL_W + 2;

	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	// Register indexes on the configuration port.
	localparam logic [2:0] REG_MEAN_LOW    = 3'd0;
	localparam logic [2:0] REG_MEAN_HIGH   = 3'd1;
	localparam logic [2:0] REG_WIDTH_LOW   = 3'd2;
	localparam logic [2:0] REG_WIDTH_HIGH  = 3'd3;
	localparam logic [2:0] REG_HEIGHT_LOW  = 3'd4;
	localparam logic [2:0] REG_HEIGHT_HIGH = 3'd5;

	// Codon kinds; bit 0 flips the Gray bit, bits 2:1 pick the class.
	localparam logic [2:0] KIND_H1 = 3'd5;

	// Class numbers.
	localparam int CLS_MEAN   = 0;
	localparam int CLS_WIDTH  = 1;
	localparam int CLS_HEIGHT = 2;
	localparam int NUM_CLS    = 3;

	// Fraction used when a class saw no codon.
	localparam logic [FRAC_BITS-1:0] FRAC_HALF = {1'b1, {(FRAC_BITS-1){1'b0}}};
	localparam logic [FRAC_BITS-1:0] FRAC_ZERO = '0;

	// Reset values of the range registers.
	localparam logic [VAL_W-1:0] RST_MEAN_LOW    = 16'd0;
	localparam logic [VAL_W-1:0] RST_MEAN_HIGH   = 16'd16384;
	localparam logic [VAL_W-1:0] RST_WIDTH_LOW   = 16'd0;
	localparam logic [VAL_W-1:0] RST_WIDTH_HIGH  = 16'd1638;
	localparam logic [VAL_W-1:0] RST_HEIGHT_LOW  = 16'hC000;
	localparam logic [VAL_W-1:0] RST_HEIGHT_HIGH = 16'd16384;

	// Final state of one class, taken on the last codon of a protein.
	typedef struct packed {
		logic [CNT_W-1:0]     count;
		logic [FRAC_BITS-1:0] prefix;
	} class_snap_t;

endpackage

// ===== hw/rtl/cgft_scale.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgft_scale
// Turns one class's count and prefix into a fraction and scales it into the
// configured range, saturating to signed Q2.14. Purely combinational.
// ----------------------------------------------------------------------------
module cgft_scale (
	input  cgft_pkg::class_snap_t              snap,
	input  logic [cgft_pkg::FRAC_BITS-1:0]     dflt,
	input  logic [cgft_pkg::VAL_W-1:0]         low,
	input  logic [cgft_pkg::VAL_W-1:0]         high,
	output logic signed [cgft_pkg::VAL_W-1:0]  value
);

	logic [cgft_pkg::FRAC_BITS-1:0]            frac;
	logic signed [cgft_pkg::FRAC_BITS:0]       frac_ext;
	logic signed [cgft_pkg::DIFF_W-1:0]        diff;
	logic signed [cgft_pkg::PROD_W-1:0]        prod;
	logic signed [cgft_pkg::PROD_W-1:0]        quot;
	logic signed [cgft_pkg::SUM_W-1:0]         sum;

	// The first n decoded bits repeated from the top down, cut at the fraction
	// width. Bits of the prefix past the count are still zero, so shifted
	// copies can simply be ORed together.
	always_comb begin
		frac = snap.prefix;
		if (snap.count == '0) begin
			frac = dflt;
		end else if (snap.count < cgft_pkg::CNT_MAX &&
		             int'(snap.count) < cgft_pkg::FRAC_BITS) begin
			frac = '0;
			for (int k = 1; k < cgft_pkg::FRAC_BITS && k < 31; k++) begin
				if (int'(snap.count) == k) begin
					for (int s = 0; s < cgft_pkg::FRAC_BITS; s += k) begin
						frac = frac | (snap.prefix >> s);
					end
				end
			end
		end
	end

	assign frac_ext = {1'b0, frac};
	assign diff     = cgft_pkg::DIFF_W'($signed(high)) - cgft_pkg::DIFF_W'($signed(low));
	assign prod     = diff * frac_ext;

	// Arithmetic shift is a floor division by 2^FRAC_BITS.
	assign quot = prod >>> cgft_pkg::FRAC_BITS;
	assign sum  = cgft_pkg::SUM_W'(quot) + cgft_pkg::SUM_W'($signed(low));

	always_comb begin
		if (sum > cgft_pkg::SUM_W'(32767)) begin
			value = 16'sh7FFF;
		end else if (sum < -cgft_pkg::SUM_W'(32768)) begin
			value = 16'sh8000;
		end else begin
			value = sum[cgft_pkg::VAL_W-1:0];
		end
	end

endmodule

// ===== hw/rtl/codon_gray_fold_triangle.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// codon_gray_fold_triangle
// Folds a stream of codon symbols into the mean, width and height of a
// triangle, each scaled into a configured signed Q2.14 range.
// ----------------------------------------------------------------------------
// Throughput: one codon beat per cycle unless stalled. A finished protein waits
//   in the snapshot register and then in the output register, so codons
//   stall only while both hold a result and the far side stalls the output.
// Result path: a codon marked last is taken into the snapshot register at
//   the edge that accepts it; its result then moves into the output register.
// Reset: arst_n clears class state, valids and ranges at once; the
//   ranges return to their documented defaults.
// ----------------------------------------------------------------------------
module codon_gray_fold_triangle (
	input  logic                          clk,
	input  logic                          arst_n,
	// Codon channel.
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [2:0]                    codon_kind,
	input  logic                          last_codon,
	// Result channel.
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [15:0]            mean_value,
	output logic signed [15:0]            width_value,
	output logic signed [15:0]            height_value,
	output logic                          functional,
	// Configuration port.
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cgft_pkg::ADDR_W-1:0]   paddr,
	input  logic [cgft_pkg::DATA_W-1:0]   pwdata,
	output logic [cgft_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);

	// ------------------------------------------------------------------
	// Configuration registers. Six 16-bit ranges, one per 32-bit word.
	// Indexes past the list are ignored on write and read back as zero.
	// ------------------------------------------------------------------
	logic [cgft_pkg::VAL_W-1:0] mean_low_q, mean_high_q;
	logic [cgft_pkg::VAL_W-1:0] width_low_q, width_high_q;
	logic [cgft_pkg::VAL_W-1:0] height_low_q, height_high_q;
	logic [2:0]                 reg_idx;
	logic                       cfg_wr;
	logic [cgft_pkg::VAL_W-1:0] rd_val;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_low_q    <= cgft_pkg::RST_MEAN_LOW;
			mean_high_q   <= cgft_pkg::RST_MEAN_HIGH;
			width_low_q   <= cgft_pkg::RST_WIDTH_LOW;
			width_high_q  <= cgft_pkg::RST_WIDTH_HIGH;
			height_low_q  <= cgft_pkg::RST_HEIGHT_LOW;
			height_high_q <= cgft_pkg::RST_HEIGHT_HIGH;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				cgft_pkg::REG_MEAN_LOW:    mean_low_q    <= pwdata[cgft_pkg::VAL_W-1:0];
				cgft_pkg::REG_MEAN_HIGH:   mean_high_q   <= pwdata[cgft_pkg::VAL_W-1:0];
				cgft_pkg::REG_WIDTH_LOW:   width_low_q   <= pwdata[cgft_pkg::VAL_W-1:0];
				cgft_pkg::REG_WIDTH_HIGH:  width_high_q  <= pwdata[cgft_pkg::VAL_W-1:0];
				cgft_pkg::REG_HEIGHT_LOW:  height_low_q  <= pwdata[cgft_pkg::VAL_W-1:0];
				cgft_pkg::REG_HEIGHT_HIGH: height_high_q <= pwdata[cgft_pkg::VAL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			cgft_pkg::REG_MEAN_LOW:    rd_val = mean_low_q;
			cgft_pkg::REG_MEAN_HIGH:   rd_val = mean_high_q;
			cgft_pkg::REG_WIDTH_LOW:   rd_val = width_low_q;
			cgft_pkg::REG_WIDTH_HIGH:  rd_val = width_high_q;
			cgft_pkg::REG_HEIGHT_LOW:  rd_val = height_low_q;
			cgft_pkg::REG_HEIGHT_HIGH: rd_val = height_high_q;
			default:                   rd_val = '0;
		endcase
	end

	assign prdata = cgft_pkg::DATA_W'(rd_val);

	// ------------------------------------------------------------------
	// Handshake. The output register moves unless it holds a beat that
	// the far side is stalling. The snapshot register loads when it is
	// empty or when its beat moves on into the output register, and the
	// codon channel stalls exactly when the snapshot register cannot load.
	// ------------------------------------------------------------------
	logic vld_s1;
	logic out_adv;
	logic s1_load;
	logic accept;

	assign out_adv  = !(out_valid && out_stall);
	assign in_stall = vld_s1 && !out_adv;
	assign s1_load  = !vld_s1 || out_adv;
	assign accept   = in_valid && !in_stall;

	// ------------------------------------------------------------------
	// Per-class state: Gray bit, saturating count, left-aligned prefix.
	// An odd kind flips the class bit, then the bit is appended to the
	// prefix while there is room and the count has not saturated.
	// Kinds 6 and 7 belong to no class and change nothing.
	// ------------------------------------------------------------------
	logic [cgft_pkg::NUM_CLS-1:0] gray_q;
	logic [cgft_pkg::CNT_W-1:0]   count_q  [cgft_pkg::NUM_CLS];
	logic [cgft_pkg::FRAC_BITS-1:0] prefix_q [cgft_pkg::NUM_CLS];

	logic [cgft_pkg::NUM_CLS-1:0]   gray_nx;
	logic [cgft_pkg::CNT_W-1:0]     count_nx  [cgft_pkg::NUM_CLS];
	logic [cgft_pkg::FRAC_BITS-1:0] prefix_nx [cgft_pkg::NUM_CLS];
	logic                           known_kind;

	assign known_kind = codon_kind <= cgft_pkg::KIND_H1;

	always_comb begin
		for (int c = 0; c < cgft_pkg::NUM_CLS; c++) begin
			gray_nx[c]   = gray_q[c];
			count_nx[c]  = count_q[c];
			prefix_nx[c] = prefix_q[c];
			if (known_kind && int'(codon_kind[2:1]) == c) begin
				gray_nx[c] = gray_q[c] ^ codon_kind[0];
				if (count_q[c] < cgft_pkg::CNT_MAX) begin
					count_nx[c] = count_q[c] + 1'b1;
					for (int b = 0; b < cgft_pkg::FRAC_BITS; b++) begin
						if (int'(count_q[c]) == cgft_pkg::FRAC_BITS - 1 - b && gray_nx[c]) begin
							prefix_nx[c][b] = 1'b1;
						end
					end
				end
			end
		end
	end

	// A last codon is folded in, handed on as a snapshot, and the class
	// state goes back to its reset value for the next protein.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gray_q <= '0;
			for (int c = 0; c < cgft_pkg::NUM_CLS; c++) begin
				count_q[c]  <= '0;
				prefix_q[c] <= '0;
			end
		end else if (accept) begin
			if (last_codon) begin
				gray_q <= '0;
				for (int c = 0; c < cgft_pkg::NUM_CLS; c++) begin
					count_q[c]  <= '0;
					prefix_q[c] <= '0;
				end
			end else begin
				gray_q <= gray_nx;
				for (int c = 0; c < cgft_pkg::NUM_CLS; c++) begin
					count_q[c]  <= count_nx[c];
					prefix_q[c] <= prefix_nx[c];
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result path: the snapshot register (s1) feeds the fraction fold,
	// the range scaling and the saturation in one pass, straight into
	// the output register.
	// ------------------------------------------------------------------
	cgft_pkg::class_snap_t        snap_s1 [cgft_pkg::NUM_CLS];
	logic [cgft_pkg::NUM_CLS-1:0] seen_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (s1_load) begin
				vld_s1 <= accept && last_codon;
			end
			if (out_adv) begin
				out_valid <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load) begin
			for (int c = 0; c < cgft_pkg::NUM_CLS; c++) begin
				snap_s1[c].count  <= count_nx[c];
				snap_s1[c].prefix <= prefix_nx[c];
				seen_s1[c]        <= count_nx[c] != '0;
			end
		end
	end

	logic signed [cgft_pkg::VAL_W-1:0] mean_s1, width_s1, height_s1;

	cgft_scale u_scale_mean (
		.snap  (snap_s1[cgft_pkg::CLS_MEAN]),
		.dflt  (cgft_pkg::FRAC_HALF),
		.low   (mean_low_q),
		.high  (mean_high_q),
		.value (mean_s1)
	);

	cgft_scale u_scale_width (
		.snap  (snap_s1[cgft_pkg::CLS_WIDTH]),
		.dflt  (cgft_pkg::FRAC_ZERO),
		.low   (width_low_q),
		.high  (width_high_q),
		.value (width_s1)
	);

	cgft_scale u_scale_height (
		.snap  (snap_s1[cgft_pkg::CLS_HEIGHT]),
		.dflt  (cgft_pkg::FRAC_HALF),
		.low   (height_low_q),
		.high  (height_high_q),
		.value (height_s1)
	);

	// The protein is functional when every class saw a codon and both
	// the width and the height came out nonzero.
	always_ff @(posedge clk) begin
		if (out_adv) begin
			mean_value   <= mean_s1;
			width_value  <= width_s1;
			height_value <= height_s1;
			functional   <= (&seen_s1) && (width_s1 != '0) && (height_s1 != '0);
		end
	end

endmodule

// ===== tb/sv/fold_tb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fold_tb_pkg
// Codon names, beat types and the triangle scoreboard for the codon Gray fold
// triangle testbench.
// ----------------------------------------------------------------------------
package fold_tb_pkg;

	import cgft_pkg::*;

	typedef enum logic [2:0] {
		CODON_MEAN_KEEP, CODON_MEAN_FLIP, CODON_WIDTH_KEEP, CODON_WIDTH_FLIP,
		CODON_HEIGHT_KEEP, CODON_HEIGHT_FLIP, CODON_SKIP6, CODON_SKIP7
	} codon_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] mean;
		logic signed [VAL_W-1:0] width;
		logic signed [VAL_W-1:0] height;
		logic                    functional;
	} triangle_t;

	class triangle_board;
		logic [VAL_W-1:0]     range_reg[6];
		logic                 gray_bit[NUM_CLS];
		logic [CNT_W-1:0]     codon_count[NUM_CLS];
		logic [FRAC_BITS-1:0] bit_prefix[NUM_CLS];
		triangle_t            pending_triangles[$];
		int                   failures;

		function new();
			range_reg[REG_MEAN_LOW]    = RST_MEAN_LOW;
			range_reg[REG_MEAN_HIGH]   = RST_MEAN_HIGH;
			range_reg[REG_WIDTH_LOW]   = RST_WIDTH_LOW;
			range_reg[REG_WIDTH_HIGH]  = RST_WIDTH_HIGH;
			range_reg[REG_HEIGHT_LOW]  = RST_HEIGHT_LOW;
			range_reg[REG_HEIGHT_HIGH] = RST_HEIGHT_HIGH;
			failures = 0;
			clear_classes();
		endfunction

		function void clear_classes();
			for (int c = 0; c < NUM_CLS; c++) begin
				gray_bit[c]    = 1'b0;
				codon_count[c] = '0;
				bit_prefix[c]  = '0;
			end
		endfunction

		function void set_range(logic [2:0] idx, logic [VAL_W-1:0] value);
			if (idx <= REG_HEIGHT_HIGH)
				range_reg[idx] = value;
		endfunction

		// A class of n decoded bits stands for M / (2^n - 1), which is the
		// n-bit prefix repeated down to the bottom of the fraction.
		function logic [FRAC_BITS-1:0] fold_fraction(int cls, logic [FRAC_BITS-1:0] dflt);
			int                   n;
			logic [FRAC_BITS-1:0] folded;
			n = codon_count[cls];
			folded = '0;
			if (n == 0)
				return dflt;
			if (n >= CNT_MAX || n >= FRAC_BITS)
				return bit_prefix[cls];
			for (int s = 0; s < FRAC_BITS; s += n)
				folded |= bit_prefix[cls] >> s;
			return folded;
		endfunction

		// low + floor((high - low) * f), clamped to signed Q2.14.
		function logic signed [VAL_W-1:0] scale_to_range(logic [FRAC_BITS-1:0] frac,
				logic [VAL_W-1:0] lo_raw, logic [VAL_W-1:0] hi_raw);
			longint lo;
			longint span;
			longint v;
			lo   = longint'($signed(lo_raw));
			span = longint'($signed(hi_raw)) - lo;
			v    = lo + ((span * longint'(frac)) >>> FRAC_BITS);
			if (v > 32767)
				v = 32767;
			if (v < -32768)
				v = -32768;
			return v[VAL_W-1:0];
		endfunction

		function void note_codon(codon_t kind, logic last);
			logic [2:0]       code;
			int               cls;
			int               k;
			triangle_t        shape;
			code = kind;
			if (kind <= CODON_HEIGHT_FLIP) begin
				cls = int'(code[2:1]);
				k   = codon_count[cls];
				gray_bit[cls] ^= code[0];
				if (k < FRAC_BITS && k < CNT_MAX && gray_bit[cls])
					bit_prefix[cls][FRAC_BITS-1-k] = 1'b1;
				if (k < CNT_MAX)
					codon_count[cls] = CNT_W'(k + 1);
			end
			if (!last)
				return;
			shape.mean   = scale_to_range(fold_fraction(CLS_MEAN, FRAC_HALF),
				range_reg[REG_MEAN_LOW], range_reg[REG_MEAN_HIGH]);
			shape.width  = scale_to_range(fold_fraction(CLS_WIDTH, FRAC_ZERO),
				range_reg[REG_WIDTH_LOW], range_reg[REG_WIDTH_HIGH]);
			shape.height = scale_to_range(fold_fraction(CLS_HEIGHT, FRAC_HALF),
				range_reg[REG_HEIGHT_LOW], range_reg[REG_HEIGHT_HIGH]);
			shape.functional = codon_count[CLS_MEAN] != 0 && codon_count[CLS_WIDTH] != 0 &&
				codon_count[CLS_HEIGHT] != 0 && shape.width != 0 && shape.height != 0;
			pending_triangles.insert(pending_triangles.size(), shape);
			clear_classes();
		endfunction

		function void check_result(triangle_t got);
			triangle_t want;
			if (pending_triangles.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("result beat with nothing pending:",
						" mean %0d width %0d", $signed(got.mean), $signed(got.width),
						" height %0d func %0b", $signed(got.height), got.functional);
				return;
			end
			want = pending_triangles.pop_front();
			if (got.mean !== want.mean || got.width !== want.width ||
					got.height !== want.height || got.functional !== want.functional) begin
				failures++;
				if (failures <= 10)
					$display("mismatch: expected mean %0d width %0d",
						$signed(want.mean), $signed(want.width),
						" height %0d func %0b,", $signed(want.height), want.functional,
						" got mean %0d width %0d", $signed(got.mean), $signed(got.width),
						" height %0d func %0b", $signed(got.height), got.functional);
			end
		endfunction
	endclass

endpackage

// ===== tb/sv/tb_codon_gray_fold_triangle.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_codon_gray_fold_triangle
// Streams codon proteins into the fold triangle block under several range
// settings and idling patterns, and checks every result beat against a
// scoreboard that folds the same codons on its own.
// ----------------------------------------------------------------------------
module tb_codon_gray_fold_triangle;

	import cgft_pkg::*;
	import fold_tb_pkg::*;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
	typedef enum int {
		RANGE_FULL, RANGE_REVERSED, RANGE_FLAT, RANGE_RANDOM, RANGE_RESET, RANGE_CORNERS
	} range_style_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic [2:0]             codon_kind = CODON_SKIP6;
	logic                   last_codon = 1'b0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic signed [15:0]     mean_value;
	logic signed [15:0]     width_value;
	logic signed [15:0]     height_value;
	logic                   functional;
	logic                   psel = 1'b0;
	logic                   penable = 1'b0;
	logic                   pwrite = 1'b0;
	logic [ADDR_W-1:0]      paddr = '0;
	logic [DATA_W-1:0]      pwdata = '0;
	logic [DATA_W-1:0]      prdata;
	logic                   pready;

	triangle_board board;
	idle_mode_t    idle_mode = IDLE_NONE;

	codon_gray_fold_triangle uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.codon_kind   (codon_kind),
		.last_codon   (last_codon),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.mean_value   (mean_value),
		.width_value  (width_value),
		.height_value (height_value),
		.functional   (functional),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #6 clk = ~clk;

	// The receiver decides its stall for the coming edge at each falling edge,
	// so stalls can hit a result beat at any point of its wait.
	always @(negedge clk) begin
		case (idle_mode)
			IDLE_RECEIVER: out_stall = $urandom_range(99) < 79;
			IDLE_BOTH:     out_stall = $urandom_range(99) < 31;
			default:       out_stall = 1'b0;
		endcase
	end

	// A result beat moves on a rising edge with valid high and stall low.
	// Everything is sampled here before the block's own registers update.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_result('{mean_value, width_value, height_value, functional});
	end

	// Idle cycles the sender inserts ahead of the next codon beat.
	function automatic int sender_gap();
		int pct;
		int gap;
		pct = (idle_mode == IDLE_SENDER) ? 79 : (idle_mode == IDLE_BOTH) ? 31 : 0;
		gap = 0;
		while (gap < 30 && $urandom_range(99) < pct)
			gap++;
		return gap;
	endfunction

	// Offers one codon beat and holds it until the block takes it. Valid is
	// left high afterwards so back-to-back beats need no drop in between;
	// whoever pauses the stream lowers it.
	task automatic push_codon(codon_t kind, logic last);
		int gap;
		gap = sender_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid   = 1'b1;
		codon_kind = kind;
		last_codon = last;
		do @(posedge clk); while (in_stall);
		board.note_codon(kind, last);
	endtask

	// Stops the codon stream and waits for every pending triangle, then lets
	// the result path run empty with some margin to spare.
	task automatic drain_triangles();
		@(negedge clk);
		in_valid = 1'b0;
		while (board.pending_triangles.size() != 0)
			@(posedge clk);
		repeat (8) @(negedge clk);
	endtask

	// Setup cycle, then access cycle; the register takes the value at the
	// edge where the access phase sees pready.
	task automatic write_range(logic [2:0] idx, logic [15:0] value);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = {{16{value[15]}}, value};
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		board.set_range(idx, value);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	function automatic logic [15:0] range_value(range_style_t style, logic is_high,
			logic [15:0] reset_value);
		case (style)
			RANGE_FULL:     return is_high ? 16'h7FFF : 16'h8000;
			RANGE_REVERSED: return is_high ? 16'h8000 : 16'h7FFF;
			RANGE_FLAT:     return 16'h0000;
			RANGE_RESET:    return reset_value;
			RANGE_CORNERS: begin
				case ($urandom_range(4))
					0:       return 16'h8000;
					1:       return 16'h7FFF;
					2:       return 16'h0000;
					3:       return 16'hFFFF;
					default: return 16'($urandom_range(65535));
				endcase
			end
			default:        return 16'($urandom_range(65535));
		endcase
	endfunction

	task automatic load_ranges(range_style_t style);
		write_range(REG_MEAN_LOW,    range_value(style, 1'b0, RST_MEAN_LOW));
		write_range(REG_MEAN_HIGH,   range_value(style, 1'b1, RST_MEAN_HIGH));
		write_range(REG_WIDTH_LOW,   range_value(style, 1'b0, RST_WIDTH_LOW));
		write_range(REG_WIDTH_HIGH,  range_value(style, 1'b1, RST_WIDTH_HIGH));
		write_range(REG_HEIGHT_LOW,  range_value(style, 1'b0, RST_HEIGHT_LOW));
		write_range(REG_HEIGHT_HIGH, range_value(style, 1'b1, RST_HEIGHT_HIGH));
	endtask

	// One protein: a run of codons closed by a beat marked last. Most are
	// short; some are long runs dominated by one class so that the prefix
	// fills up and the count saturates. A few codons are ignored kinds.
	task automatic run_protein(ref int counted);
		int     len;
		int     focus;
		int     pick;
		codon_t kind;
		pick  = $urandom_range(99);
		focus = -1;
		if (pick < 70)
			len = $urandom_range(10);
		else if (pick < 90)
			len = $urandom_range(24, 11);
		else begin
			len   = $urandom_range(45, 25);
			focus = $urandom_range(NUM_CLS - 1);
		end
		for (int i = 0; i <= len; i++) begin
			if (focus >= 0 && $urandom_range(99) < 80)
				kind = codon_t'(2 * focus + $urandom_range(1));
			else if ($urandom_range(99) < 8)
				kind = $urandom_range(1) ? CODON_SKIP7 : CODON_SKIP6;
			else
				kind = codon_t'($urandom_range(CODON_HEIGHT_FLIP));
			push_codon(kind, i == len);
			counted++;
		end
	endtask

	initial begin
		range_style_t styles[8];
		int           counted;
		board = new();
		styles = '{RANGE_FULL, RANGE_REVERSED, RANGE_FLAT, RANGE_RANDOM,
			RANGE_RESET, RANGE_CORNERS, RANGE_RANDOM, RANGE_CORNERS};

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed proteins under the reset ranges. An ignored kind marked
		// last on empty state gives all three defaults.
		push_codon(CODON_SKIP6, 1'b1);
		// Each of the six class codon kinds once, closing on a flipping height codon.
		push_codon(CODON_MEAN_KEEP, 1'b0);
		push_codon(CODON_MEAN_FLIP, 1'b0);
		push_codon(CODON_WIDTH_KEEP, 1'b0);
		push_codon(CODON_WIDTH_FLIP, 1'b0);
		push_codon(CODON_HEIGHT_KEEP, 1'b0);
		push_codon(CODON_HEIGHT_FLIP, 1'b1);
		// A single set width bit folds into the all-ones fraction.
		push_codon(CODON_WIDTH_FLIP, 1'b1);
		// The other ignored kind still closes a protein that has state.
		push_codon(CODON_MEAN_FLIP, 1'b0);
		push_codon(CODON_SKIP7, 1'b1);
		// A lone clear height bit lands on the low bound.
		push_codon(CODON_HEIGHT_KEEP, 1'b1);
		// Three mean bits and two each of width and height fold short patterns.
		push_codon(CODON_MEAN_FLIP, 1'b0);
		push_codon(CODON_MEAN_KEEP, 1'b0);
		push_codon(CODON_MEAN_FLIP, 1'b0);
		push_codon(CODON_WIDTH_FLIP, 1'b0);
		push_codon(CODON_WIDTH_KEEP, 1'b0);
		push_codon(CODON_HEIGHT_FLIP, 1'b0);
		push_codon(CODON_HEIGHT_FLIP, 1'b1);

		// Random phases. Each one drains, which also makes the sender wait
		// for every pending triangle, then reloads the ranges and cycles to
		// the next idling pattern.
		for (int ph = 0; ph < 8; ph++) begin
			drain_triangles();
			load_ranges(styles[ph]);
			idle_mode = idle_mode_t'(ph % 4);
			counted = 0;
			while (counted < 225)
				run_protein(counted);
		end

		drain_triangles();
		idle_mode = IDLE_NONE;
		repeat (10) @(posedge clk);
		board.failures += board.pending_triangles.size();
		if (board.failures == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
